### rtl/core/assert_macros.svh
// Assertion macros for the top-level RTL file, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

### rtl/core/mols_pkg.sv
// Package for the median unit: constants, command and status types.
`timescale 1ns / 1ps

package mols_pkg;

  localparam int MaxSamplesDef = 64;
  localparam int SampleW       = 32;
  localparam int MedianW       = 33;
  localparam int SizeW         = 7;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_NEXT,
    RD_MID_LO,
    RD_MID_HI
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_IN,
    WR_SHIFT,
    WR_X
  } wr_sel_e;

  typedef enum logic [1:0] {
    MED_NONE,
    MED_DOUBLE,
    MED_FIRST,
    MED_SECOND
  } med_op_e;

  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    pos_dec;
    logic    cnt_inc;
    logic    ovf_set;
    med_op_e med_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic greater;
    logic pos_one;
    logic odd;
    logic last;
  } status_t;

endpackage

### rtl/core/mols_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mols_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/mols_datapath.sv
// Datapath: sorted sample store, insertion pointer, count and median adder.
`timescale 1ns / 1ps

module mols_datapath import mols_pkg::*; #(
  parameter int MAX_SAMPLES = MaxSamplesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      in_last_sample_i,
  output logic signed [MedianW-1:0] out_median_doubled_o,
  output logic        [SizeW-1:0]   out_set_size_o,
  output logic                      out_overflowed_o
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int AddrW = $clog2(MAX_SAMPLES);

  logic [CntW-1:0]           count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic [AddrW-1:0]          pos_q;
  logic [SampleW-1:0]        sample_q;
  logic                      last_q;
  logic signed [MedianW-1:0] acc_q;
  logic signed [MedianW-1:0] median_q;
  logic [SizeW-1:0]          size_q;
  logic                      ovf_out_q;

  logic [CntW-1:0]    half;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [SampleW-1:0] wr_data;
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic [SampleW-1:0] rd_data;
  logic signed [MedianW-1:0] rd_ext;

  assign half   = count_q >> 1;
  assign rd_ext = MedianW'($signed(rd_data));

  always_comb begin
    rd_en   = (cmd_i.rd_sel != RD_NONE);
    rd_addr = '0;
    case (cmd_i.rd_sel)
      RD_TOP:    rd_addr = AddrW'(count_q - CntW'(1));
      RD_NEXT:   rd_addr = pos_q - AddrW'(2);
      RD_MID_LO: rd_addr = AddrW'(half - CntW'(1));
      RD_MID_HI: rd_addr = AddrW'(half);
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = (cmd_i.wr_sel != WR_NONE);
    wr_addr = pos_q;
    wr_data = sample_q;
    case (cmd_i.wr_sel)
      WR_IN: begin
        wr_addr = AddrW'(count_q);
        wr_data = in_sample_i;
      end
      WR_SHIFT: begin
        wr_data = rd_data;
      end
      default: begin
        wr_addr = pos_q;
        wr_data = sample_q;
      end
    endcase
  end

  mols_ram #(
    .Width (SampleW),
    .Depth (MAX_SAMPLES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.ovf_set) begin
      ovf_d = 1'b1;
    end
    // start a new set once the result is handed off
    if (cmd_i.out_load) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_sample_i;
      last_q   <= in_last_sample_i;
      pos_q    <= AddrW'(count_q);
    end else if (cmd_i.pos_dec) begin
      pos_q <= pos_q - AddrW'(1);
    end
    case (cmd_i.med_op)
      MED_DOUBLE: acc_q <= rd_ext <<< 1;
      MED_FIRST:  acc_q <= rd_ext;
      MED_SECOND: acc_q <= acc_q + rd_ext;
      default:    acc_q <= acc_q;
    endcase
    if (cmd_i.out_load) begin
      median_q  <= acc_q;
      size_q    <= SizeW'(count_q);
      ovf_out_q <= ovf_q;
    end
  end

  assign status_o.full    = (count_q == CntW'(MAX_SAMPLES));
  assign status_o.empty   = (count_q == '0);
  assign status_o.greater = ($signed(rd_data) > $signed(sample_q));
  assign status_o.pos_one = (pos_q == AddrW'(1));
  assign status_o.odd     = count_q[0];
  assign status_o.last    = last_q;

  assign out_median_doubled_o = median_q;
  assign out_set_size_o       = size_q;
  assign out_overflowed_o     = ovf_out_q;

endmodule

### rtl/core/mols_ctrl.sv
// Controller: sequences insertion, median readout and result hand-off.
`timescale 1ns / 1ps

module mols_ctrl import mols_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_sample_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_MED_LO,
    S_MED_HI,
    S_MED_SUM,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_NONE;
    cmd_o.wr_sel = WR_NONE;
    cmd_o.med_op = MED_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.full) begin
            // drop the item, remember the loss
            cmd_o.ovf_set = 1'b1;
            if (in_last_sample_i) begin
              state_d = S_MED_LO;
            end
          end else if (status_i.empty) begin
            cmd_o.wr_sel  = WR_IN;
            cmd_o.cnt_inc = 1'b1;
            if (in_last_sample_i) begin
              state_d = S_MED_LO;
            end
          end else begin
            cmd_o.load   = 1'b1;
            cmd_o.rd_sel = RD_TOP;
            state_d      = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (status_i.greater) begin
          // move the larger entry up one slot
          cmd_o.wr_sel  = WR_SHIFT;
          cmd_o.pos_dec = 1'b1;
          if (status_i.pos_one) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.rd_sel = RD_NEXT;
          end
        end else begin
          cmd_o.wr_sel  = WR_X;
          cmd_o.cnt_inc = 1'b1;
          state_d       = status_i.last ? S_MED_LO : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd_o.wr_sel  = WR_X;
        cmd_o.cnt_inc = 1'b1;
        state_d       = status_i.last ? S_MED_LO : S_IDLE;
      end
      S_MED_LO: begin
        cmd_o.rd_sel = status_i.odd ? RD_MID_HI : RD_MID_LO;
        state_d      = S_MED_HI;
      end
      S_MED_HI: begin
        if (status_i.odd) begin
          cmd_o.med_op = MED_DOUBLE;
          state_d      = S_EMIT;
        end else begin
          cmd_o.med_op = MED_FIRST;
          cmd_o.rd_sel = RD_MID_HI;
          state_d      = S_MED_SUM;
        end
      end
      S_MED_SUM: begin
        cmd_o.med_op = MED_SECOND;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/median_of_loaded_set_unit.sv
// Top level of the median unit: controller, datapath and checks.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_sample_i, in_last_sample_i
//  out     | output    | out_valid_o/out_stall_i | out_median_doubled_o, out_set_size_o,
//          |           |                     | out_overflowed_o
//
// An item takes an accept step, a shift step per kept sample greater than it and a
// placing step (only the accept step when the set is empty or full); each shifted
// entry takes a step on the store's single read and write port. A closing item adds
// a median read, then doubling (odd count) or a second read and sum (even count).
// Reset clears only count, flags and state; the sample store needs no clearing pass.
// A result waits in the output register while the next set loads; a stalled
// output only holds the unit once the following result is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module median_of_loaded_set_unit import mols_pkg::*; #(
  parameter int MAX_SAMPLES = MaxSamplesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      in_last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [MedianW-1:0] out_median_doubled_o,
  output logic        [SizeW-1:0]   out_set_size_o,
  output logic                      out_overflowed_o
);

  cmd_t    cmd;
  status_t status;
  logic    out_free;
  logic    store_busy;

  mols_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_last_sample_i (in_last_sample_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  mols_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .in_sample_i          (in_sample_i),
    .in_last_sample_i     (in_last_sample_i),
    .out_median_doubled_o (out_median_doubled_o),
    .out_set_size_o       (out_set_size_o),
    .out_overflowed_o     (out_overflowed_o)
  );

  assign out_free   = !out_valid_o || !out_stall_i;
  assign store_busy = cmd.wr_sel inside {WR_SHIFT, WR_X};

  `ASSERT_CLK(a_no_result_overwrite, cmd.out_load |-> out_free, "pending result overwritten")
  `ASSERT_CLK(a_result_shown, cmd.out_load |=> out_valid_o, "loaded result not presented")
  `ASSERT_NEVER(a_count_bound, cmd.cnt_inc && status.full, "sample count past capacity")
  `ASSERT_NEVER(a_store_busy_accept, !in_stall_o && store_busy, "item taken during insertion")

endmodule
